// ===== sv/escaped_packet_framer_core_assert.svh =====
// Assertion macros shared by the escaped packet framer RTL
`ifndef ESCAPED_PACKET_FRAMER_CORE_ASSERT_SVH
`define ESCAPED_PACKET_FRAMER_CORE_ASSERT_SVH

// condition holds at every clock outside reset
`define EFR_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("efr assertion failed");

// consequent holds in the same cycle as the antecedent
`define EFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("efr assertion failed");

// consequent holds in the cycle after the antecedent
`define EFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("efr assertion failed");

`endif

// ===== sv/efr_pkg.sv =====
// Types and constants of the escaped packet framer
`default_nettype none
package efr_pkg;

    localparam int FRAME_MAX = 9;
    localparam int LEN_W     = 4;
    localparam int NUM_PAY   = 4;

    localparam logic [7:0] CKSUM_SEED = 8'hFF;

    typedef logic [7:0] t_byte;
    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [1:0] {
        REG_HEADER = 2'd0,
        REG_ESCAPE = 2'd1,
        REG_STRIP  = 2'd2,
        REG_REPLY  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_byte header;
        t_byte escape;
        t_byte strip;
        t_byte reply;
    } t_cfg;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        t_len                      len;
    } t_frame;

endpackage
`default_nettype wire

// ===== sv/efr_cfg.sv =====
// APB register file holding the framer configuration
`default_nettype none
module efr_cfg
    import efr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_HEADER: n_cfg.header = pwdata[7:0];
                REG_ESCAPE: n_cfg.escape = pwdata[7:0];
                REG_STRIP:  n_cfg.strip  = pwdata[7:0];
                REG_REPLY:  n_cfg.reply  = pwdata[7:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HEADER: prdata = {24'd0, r_cfg.header};
            REG_ESCAPE: prdata = {24'd0, r_cfg.escape};
            REG_STRIP:  prdata = {24'd0, r_cfg.strip};
            REG_REPLY:  prdata = {24'd0, r_cfg.reply};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header <= 8'hC0;
            r_cfg.escape <= 8'hC1;
            r_cfg.strip  <= 8'hC0;
            r_cfg.reply  <= 8'h80;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ===== sv/efr_plan.sv =====
// Frame builder: lays out header, escaped payload and checksum bytes
`default_nettype none
module efr_plan
    import efr_pkg::*;
(
    input  wire t_cfg        i_cfg,
    input  wire logic [7:0]  i_cmd,
    input  wire logic [7:0]  i_arg_first,
    input  wire logic [7:0]  i_arg_second,
    output t_frame           o_frame
);

    logic  w_reply;
    t_byte w_sum;

    assign w_reply = (i_cmd & i_cfg.reply) != 8'd0;
    assign w_sum   = w_reply ? (i_cmd ^ CKSUM_SEED ^ i_arg_first ^ i_arg_second)
                             : (i_cmd ^ CKSUM_SEED);

    always_comb begin
        t_byte                    pay [NUM_PAY];
        logic [NUM_PAY-1:0]       en;
        logic [FRAME_MAX-1:0][7:0] slots;
        t_len                     pos;
        pay[0] = i_cmd;
        pay[1] = i_arg_first;
        pay[2] = i_arg_second;
        pay[3] = w_sum;
        en     = {1'b1, w_reply, w_reply, 1'b1};
        slots  = '0;
        slots[0] = i_cfg.header;
        pos    = t_len'(1);
        for (int k = 0; k < NUM_PAY; k++) begin
            if (en[k]) begin
                if (pay[k] == i_cfg.header || pay[k] == i_cfg.escape) begin
                    slots[pos]             = i_cfg.escape;
                    slots[pos + t_len'(1)] = pay[k] & ~i_cfg.strip;
                    pos = pos + t_len'(2);
                end else begin
                    slots[pos] = pay[k];
                    pos = pos + t_len'(1);
                end
            end
        end
        o_frame.bytes = slots;
        o_frame.len   = pos;
    end

endmodule
`default_nettype wire

// ===== sv/efr_ser.sv =====
// Output shift line that sends a built frame one word per cycle while i_tready is high
`default_nettype none
module efr_ser
    import efr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_frame i_frame,
    input  wire logic  i_tready,
    output logic       o_can_load,
    output logic       o_tvalid,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    `include "escaped_packet_framer_core_assert.svh"

    logic [FRAME_MAX-1:0][7:0] r_bytes;
    logic [FRAME_MAX-1:0][7:0] n_bytes;
    t_len                      r_rem;
    t_len                      n_rem;
    logic                      w_take;

    assign o_tvalid   = r_rem != t_len'(0);
    assign o_tlast    = r_rem == t_len'(1);
    assign o_tdata    = r_bytes[0];
    assign w_take     = o_tvalid && i_tready;
    assign o_can_load = !o_tvalid || (w_take && o_tlast);

    always_comb begin
        n_bytes = r_bytes;
        n_rem   = r_rem;
        if (i_load) begin
            n_bytes = i_frame.bytes;
            n_rem   = i_frame.len;
        end else if (w_take) begin
            // advance to the next word
            n_bytes = {8'd0, r_bytes[FRAME_MAX-1:1]};
            n_rem   = r_rem - t_len'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    `EFR_ASSERT(a_rem_bound, r_rem <= t_len'(FRAME_MAX))
    `EFR_ASSERT_IMPL(a_load_when_free, i_load,
        r_rem == t_len'(0) || (r_rem == t_len'(1) && i_tready))
    `EFR_ASSERT_NEXT(a_rem_step, w_take && !o_tlast && !i_load,
        r_rem == t_len'($past(r_rem) - t_len'(1)))
    `EFR_ASSERT_NEXT(a_load_len, i_load, r_rem == $past(i_frame.len) && o_tvalid)

endmodule
`default_nettype wire

// ===== sv/escaped_packet_framer_core.sv =====
// Top level of the escaped packet framer: input register, builder, output line
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | i_s_axis_tvalid/o_..tready | tdata: cmd_byte, arg_first, arg_second
//  m_axis    | out | o_m_axis_tvalid/i_..tready | tdata: wire_byte; tlast: frame_end
//  apb       | in  | psel, penable, pready      | header, escape, strip, reply regs
//
// A packet becomes a frame of 3 to 9 words: 3, plus 2 with a reply bit, plus
// one per escaped byte; the output line sends one word per cycle while m_axis
// is ready. A packet waits in the input register and is built as it moves
// into the output line, which happens when the line is empty or its last
// word leaves. The next packet is taken while the previous frame drains, so
// frames leave without gaps. Reset is synchronous and empties both stages.
// A stall on m_axis holds the word.
`default_nettype none
module escaped_packet_framer_core
    import efr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [7:0] cmd_byte, [15:8] arg_first, [23:16] arg_second
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] wire_byte
    output logic             o_m_axis_tlast,   // frame_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    `include "escaped_packet_framer_core_assert.svh"

    t_cfg        w_cfg;
    t_frame      w_frame;
    logic        w_can_load;
    logic        w_load;
    logic        w_in_take;
    logic        r_in_vld;
    logic        n_in_vld;
    logic [23:0] r_in_data;

    efr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    efr_plan u_plan (
        .i_cfg        (w_cfg),
        .i_cmd        (r_in_data[7:0]),
        .i_arg_first  (r_in_data[15:8]),
        .i_arg_second (r_in_data[23:16]),
        .o_frame      (w_frame)
    );

    efr_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_frame    (w_frame),
        .i_tready   (i_m_axis_tready),
        .o_can_load (w_can_load),
        .o_tvalid   (o_m_axis_tvalid),
        .o_tdata    (o_m_axis_tdata),
        .o_tlast    (o_m_axis_tlast)
    );

    assign w_load          = r_in_vld && w_can_load;
    assign o_s_axis_tready = !r_in_vld || w_load;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (w_in_take) begin
            n_in_vld = 1'b1;
        end else if (w_load) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    `EFR_ASSERT_NEXT(a_in_held, w_in_take, r_in_vld && r_in_data == $past(i_s_axis_tdata))
    `EFR_ASSERT_NEXT(a_in_wait, r_in_vld && !w_load, r_in_vld && $stable(r_in_data))

endmodule
`default_nettype wire

// ===== bench/escaped_packet_framer_checker.sv =====
// Checker for the escaped packet framer: predicts each frame and compares every wire word
`default_nettype none
module escaped_packet_framer_checker
    import efr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // [7:0] cmd_byte, [15:8] arg_first, [23:16] arg_second
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [7:0]  i_m_axis_tdata,   // [7:0] wire_byte
    input  wire logic        i_m_axis_tlast,   // frame_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_cnt,
    output int               o_pending_cnt
);

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_framed_word;

    t_cfg         cfg;
    t_framed_word wire_q[$];
    int           fail_cnt = 0;

    function automatic void push_word(input t_byte b, input logic last);
        t_framed_word w;
        w.data = b;
        w.last = last;
        wire_q.push_back(w);
    endfunction

    function automatic void push_payload(input t_byte b, input logic last);
        if (b == cfg.header || b == cfg.escape) begin
            push_word(cfg.escape, 1'b0);
            push_word(b & ~cfg.strip, last);
        end else begin
            push_word(b, last);
        end
    endfunction

    function automatic void frame_packet(input t_byte cmd, input t_byte a1, input t_byte a2);
        t_byte sum;
        sum = cmd ^ CKSUM_SEED;
        push_word(cfg.header, 1'b0);
        push_payload(cmd, 1'b0);
        if ((cmd & cfg.reply) != 8'h00) begin
            push_payload(a1, 1'b0);
            push_payload(a2, 1'b0);
            sum = sum ^ a1 ^ a2;
        end
        push_payload(sum, 1'b1);
    endfunction

    always @(posedge i_clk) begin : watch
        t_framed_word want;
        t_reg_idx     idx;
        if (!i_rst_n) begin
            cfg.header = 8'hC0;
            cfg.escape = 8'hC1;
            cfg.strip  = 8'hC0;
            cfg.reply  = 8'h80;
            wire_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = t_reg_idx'(paddr[3:2]);
                case (idx)
                    REG_HEADER: cfg.header = pwdata[7:0];
                    REG_ESCAPE: cfg.escape = pwdata[7:0];
                    REG_STRIP:  cfg.strip  = pwdata[7:0];
                    REG_REPLY:  cfg.reply  = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                frame_packet(i_s_axis_tdata[7:0], i_s_axis_tdata[15:8], i_s_axis_tdata[23:16]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (wire_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %02h last %0b",
                             $time, i_m_axis_tdata, i_m_axis_tlast);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = wire_q.pop_front();
                    if (i_m_axis_tdata !== want.data) begin
                        $display("%0t: wire_byte mismatch, expected %02h, actual %02h",
                                 $time, want.data, i_m_axis_tdata);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                                 $time, want.last, i_m_axis_tlast);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
        end
        o_fail_cnt    <= fail_cnt;
        o_pending_cnt <= wire_q.size();
    end

endmodule
`default_nettype wire

// ===== bench/tb_escaped_packet_framer_core.sv =====
// Testbench top for the escaped packet framer: packet and register stimulus, verdict
`default_nettype none
module tb_escaped_packet_framer_core;
    import efr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 12;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [23:0] i_s_axis_tdata  = 24'h000000;
    logic        i_m_axis_tready = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [3:0]  paddr           = 4'h0;
    logic [31:0] pwdata          = 32'h0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [31:0] prdata;
    logic        pready;

    int    fail_cnt;
    int    pending_cnt;
    int    cycle_cnt = 0;
    bit    no_idle   = 1'b0;
    bit    rx_hold   = 1'b0;
    t_byte cur_hdr   = 8'hC0;
    t_byte cur_esc   = 8'hC1;
    t_byte cur_reply = 8'h80;

    escaped_packet_framer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    escaped_packet_framer_checker u_framer_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_cnt      (fail_cnt),
        .o_pending_cnt   (pending_cnt)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : wire_sink
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_packet(input t_byte cmd, input t_byte a1, input t_byte a2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {a2, a1, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input t_byte val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FF00) | {24'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEADER: cur_hdr   = val;
            REG_ESCAPE: cur_esc   = val;
            REG_REPLY:  cur_reply = val;
            default: ;
        endcase
    endtask

    // drop valid, then hold until every predicted word has left the block
    task automatic drain_frames();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_byte pick_byte();
        case ($urandom_range(0, 5))
            0: return cur_hdr;
            1: return cur_esc;
            2: return 8'h00;
            3: return 8'hFF;
            default: return t_byte'($urandom());
        endcase
    endfunction

    function automatic t_byte pick_mask();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_byte'($urandom());
        endcase
    endfunction

    task automatic random_config();
        t_byte hdr;
        hdr = t_byte'($urandom());
        write_reg(REG_HEADER, hdr);
        write_reg(REG_ESCAPE, ($urandom_range(0, 3) == 0) ? hdr : t_byte'($urandom()));
        write_reg(REG_STRIP, pick_mask());
        write_reg(REG_REPLY, pick_mask());
    endtask

    task automatic random_packets(input int n);
        t_byte cmd;
        t_byte a1;
        t_byte a2;
        t_byte target;
        for (int k = 0; k < n; k++) begin
            cmd = pick_byte();
            a1  = pick_byte();
            a2  = pick_byte();
            // steer the checksum onto a framing byte
            if ($urandom_range(0, 3) == 0) begin
                target = $urandom_range(0, 1) ? cur_hdr : cur_esc;
                if ((cmd & cur_reply) != 8'h00) begin
                    a2 = target ^ cmd ^ CKSUM_SEED ^ a1;
                end else begin
                    cmd = target ^ CKSUM_SEED;
                end
            end
            send_packet(cmd, a1, a2);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'hFF, 8'hFF, 8'hFF);
        send_packet(8'hC0, 8'hC0, 8'hC1);
        send_packet(8'hC1, 8'h00, 8'hFF);
        send_packet(8'h3F, 8'h55, 8'hAA);
        send_packet(8'h3E, 8'hAA, 8'h55);
        send_packet(8'h80, 8'h00, 8'hBE);
        send_packet(8'h7F, 8'hA5, 8'h5A);
        drain_frames();

        write_reg(REG_HEADER, 8'h7E);
        write_reg(REG_ESCAPE, 8'h7E);
        write_reg(REG_STRIP, 8'h00);
        write_reg(REG_REPLY, 8'hFF);
        send_packet(8'h7E, 8'h7E, 8'h7E);
        send_packet(8'h01, 8'h7E, 8'h00);
        send_packet(8'h81, 8'h00, 8'h00);
        send_packet(8'h00, 8'h12, 8'h34);
        drain_frames();

        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_ESCAPE, 8'hFF);
        write_reg(REG_STRIP, 8'hFF);
        write_reg(REG_REPLY, 8'h00);
        send_packet(8'h00, 8'hFF, 8'hFF);
        send_packet(8'hFF, 8'h00, 8'h00);
        send_packet(8'h5A, 8'hFF, 8'h00);
        drain_frames();

        for (int p = 0; p < 5; p++) begin
            random_config();
            no_idle = (p == 1);
            rx_hold = (p == 2);
            random_packets(26);
            drain_frames();
        end
        no_idle = 1'b0;

        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/efr_pkg.sv
sv/efr_cfg.sv
sv/efr_plan.sv
sv/efr_ser.sv
sv/escaped_packet_framer_core.sv
bench/escaped_packet_framer_checker.sv
bench/tb_escaped_packet_framer_core.sv
